// ===== hw/rtl/mahq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mahq_pkg: shared types and constants of the m-ary min-heap queue
// Request and result item layouts, request kinds and status codes.
// ----------------------------------------------------------------------------
package mahq_pkg;

  localparam int unsigned DefDepth   = 1024;
  localparam int unsigned ArityW     = 4;
  localparam logic [3:0]  ArityReset = 4'd2;
  localparam logic [3:0]  ArityMin   = 4'd2;
  localparam logic [3:0]  ArityMax   = 4'd8;
  localparam int unsigned CountW     = 11;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_PEEK   = 2'd2,
    KIND_CHANGE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] key;
    logic signed [31:0] new_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] min_key;
    logic [CountW-1:0]  entry_count;
    status_e            status;
  } rsp_t;

endpackage

// ===== hw/rtl/m_ary_min_heap_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m_ary_min_heap_queue_unit: min-heap priority queue with programmable arity
// Keys live in one synchronous-read memory; a sequencer sifts a held key
// through a hole, one memory access per cycle.
// ----------------------------------------------------------------------------
// steps: insert climbs one level per multiply, divide and compare state; remove
//   scans up to arity children per level descended; change-key searches slots first
// throughput: one item at a time, set by the single memory read port
// reset: count cleared, arity 2; key memory is not cleared and needs no sweep
module m_ary_min_heap_queue_unit #(
  parameter int unsigned DEPTH = mahq_pkg::DefDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mahq_pkg::req_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mahq_pkg::rsp_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [mahq_pkg::ArityW-1:0]   cfg_data_i
);
  import mahq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned K  = AW + 2;
  localparam int unsigned PW = AW + K;
  localparam int unsigned FW = AW + 4;
  localparam logic [K-1:0] Recip2 = K'((1 << K) / 2);
  localparam logic [K-1:0] Recip3 = K'((1 << K) / 3);
  localparam logic [K-1:0] Recip4 = K'((1 << K) / 4);
  localparam logic [K-1:0] Recip5 = K'((1 << K) / 5);
  localparam logic [K-1:0] Recip6 = K'((1 << K) / 6);
  localparam logic [K-1:0] Recip7 = K'((1 << K) / 7);
  localparam logic [K-1:0] Recip8 = K'((1 << K) / 8);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_DISP    = 13'b0000000000010,
    S_RM_GET  = 13'b0000000000100,
    S_UP_MUL  = 13'b0000000001000,
    S_UP_DIV  = 13'b0000000010000,
    S_UP_CMP  = 13'b0000000100000,
    S_UP_ROOT = 13'b0000001000000,
    S_DN_INIT = 13'b0000010000000,
    S_DN_SCAN = 13'b0000100000000,
    S_DN_DEC  = 13'b0001000000000,
    S_SR_SCAN = 13'b0010000000000,
    S_FIN     = 13'b0100000000000,
    S_SPARE   = 13'b1000000000000
  } state_e;

  state_e             state_q, state_d;
  req_t               req_q, req_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [ArityW-1:0]  arity_q;
  logic [31:0]        root_q;
  logic [31:0]        cur_key_q, cur_key_d;
  logic [AW-1:0]      cur_idx_q, cur_idx_d;
  logic [PW-1:0]      prod_q, prod_d;
  logic [AW-1:0]      par_idx_q, par_idx_d;
  logic [FW-1:0]      first_q, first_d;
  logic [3:0]         j_q, j_d;
  logic               pend_q, pend_d;
  logic [AW-1:0]      rd_idx_q, rd_idx_d;
  logic [31:0]        best_key_q, best_key_d;
  logic [AW-1:0]      best_idx_q, best_idx_d;
  logic               best_vld_q, best_vld_d;
  logic               chg_q, chg_d;
  logic [CW-1:0]      scan_q, scan_d;
  status_e            status_q, status_d;
  logic               out_valid_q, out_valid_d;
  rsp_t               out_data_q, out_data_d;

  logic [31:0]        mem_q [DEPTH];
  logic [31:0]        rd_data_q;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [31:0]        wr_data;

  logic [3:0]         arity;
  logic [K-1:0]       recip;
  logic [AW-1:0]      idx_m1;
  logic [AW-1:0]      q0;
  logic [FW-1:0]      rem;
  logic [AW-1:0]      parent;
  logic [FW-1:0]      first;
  logic [FW-1:0]      child;

  always_comb begin
    if (arity_q < ArityMin) begin
      arity = ArityMin;
    end else if (arity_q > ArityMax) begin
      arity = ArityMax;
    end else begin
      arity = arity_q;
    end
  end

  always_comb begin
    unique case (arity)
      4'd3:    recip = Recip3;
      4'd4:    recip = Recip4;
      4'd5:    recip = Recip5;
      4'd6:    recip = Recip6;
      4'd7:    recip = Recip7;
      4'd8:    recip = Recip8;
      default: recip = Recip2;
    endcase
  end

  // parent index (i-1)/arity by reciprocal, then one correction step
  assign idx_m1 = cur_idx_q - AW'(1);
  assign q0     = prod_q[PW-1:K];
  assign rem    = FW'(idx_m1) - FW'(q0) * FW'(arity);
  assign parent = (rem >= FW'(arity)) ? q0 + AW'(1) : q0;
  assign first  = FW'(cur_idx_q) * FW'(arity) + FW'(1);
  assign child  = first_q + FW'(j_q);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    cnt_d       = cnt_q;
    cur_key_d   = cur_key_q;
    cur_idx_d   = cur_idx_q;
    prod_d      = prod_q;
    par_idx_d   = par_idx_q;
    first_d     = first_q;
    j_d         = j_q;
    pend_d      = pend_q;
    rd_idx_d    = rd_idx_q;
    best_key_d  = best_key_q;
    best_idx_d  = best_idx_q;
    best_vld_d  = best_vld_q;
    chg_d       = chg_q;
    scan_d      = scan_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = cur_idx_q;
    wr_data     = cur_key_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        status_d = ST_OK;
        chg_d    = 1'b0;
        if (req_q.kind == KIND_INSERT) begin
          if (cnt_q == CW'(DEPTH)) begin
            status_d = ST_FULL;
            state_d  = S_FIN;
          end else begin
            cnt_d     = cnt_q + CW'(1);
            cur_key_d = req_q.key;
            cur_idx_d = cnt_q[AW-1:0];
            if (cnt_q == '0) begin
              wr_en   = 1'b1;
              wr_addr = '0;
              wr_data = req_q.key;
              state_d = S_FIN;
            end else begin
              state_d = S_UP_MUL;
            end
          end
        end else if (cnt_q == '0) begin
          status_d = ST_EMPTY;
          state_d  = S_FIN;
        end else if (req_q.kind == KIND_REMOVE) begin
          cnt_d = cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            state_d = S_FIN;
          end else begin
            rd_addr = AW'(cnt_q - CW'(1));
            state_d = S_RM_GET;
          end
        end else if (req_q.kind == KIND_CHANGE) begin
          scan_d  = '0;
          pend_d  = 1'b0;
          state_d = S_SR_SCAN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_RM_GET: begin
        cur_key_d = rd_data_q;
        cur_idx_d = '0;
        state_d   = S_DN_INIT;
      end
      S_UP_MUL: begin
        prod_d  = PW'(idx_m1) * PW'(recip);
        state_d = S_UP_DIV;
      end
      S_UP_DIV: begin
        rd_addr   = parent;
        par_idx_d = parent;
        state_d   = S_UP_CMP;
      end
      S_UP_CMP: begin
        if ($signed(cur_key_q) < $signed(rd_data_q)) begin
          wr_en     = 1'b1;
          wr_data   = rd_data_q;
          cur_idx_d = par_idx_q;
          chg_d     = 1'b0;
          state_d   = (par_idx_q == '0) ? S_UP_ROOT : S_UP_MUL;
        end else if (chg_q) begin
          // changed key not below its parent: it may have to go down
          chg_d   = 1'b0;
          state_d = S_DN_INIT;
        end else begin
          wr_en   = 1'b1;
          state_d = S_FIN;
        end
      end
      S_UP_ROOT: begin
        wr_en   = 1'b1;
        state_d = S_FIN;
      end
      S_DN_INIT: begin
        first_d = first;
        if (first >= FW'(cnt_q)) begin
          wr_en   = 1'b1;
          state_d = S_FIN;
        end else begin
          j_d        = '0;
          pend_d     = 1'b0;
          best_vld_d = 1'b0;
          state_d    = S_DN_SCAN;
        end
      end
      S_DN_SCAN: begin
        if (pend_q && (!best_vld_q || $signed(rd_data_q) < $signed(best_key_q))) begin
          best_key_d = rd_data_q;
          best_idx_d = rd_idx_q;
          best_vld_d = 1'b1;
        end
        if (j_q < arity && child < FW'(cnt_q)) begin
          rd_addr  = child[AW-1:0];
          rd_idx_d = child[AW-1:0];
          pend_d   = 1'b1;
          j_d      = j_q + 4'd1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_DN_DEC;
          end
        end
      end
      S_DN_DEC: begin
        wr_en = 1'b1;
        if ($signed(best_key_q) < $signed(cur_key_q)) begin
          wr_data   = best_key_q;
          cur_idx_d = best_idx_q;
          state_d   = S_DN_INIT;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SR_SCAN: begin
        if (pend_q && rd_data_q == req_q.key) begin
          cur_key_d = req_q.new_value;
          cur_idx_d = rd_idx_q;
          pend_d    = 1'b0;
          chg_d     = 1'b1;
          state_d   = (rd_idx_q == '0) ? S_DN_INIT : S_UP_MUL;
        end else if (scan_q < cnt_q) begin
          rd_addr  = scan_q[AW-1:0];
          rd_idx_d = scan_q[AW-1:0];
          pend_d   = 1'b1;
          scan_d   = scan_q + CW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            status_d = ST_NOTFOUND;
            state_d  = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d             = 1'b1;
          out_data_d.min_key      = (cnt_q == '0) ? '0 : root_q;
          out_data_d.entry_count  = CountW'(cnt_q);
          out_data_d.status       = status_q;
          state_d                 = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      arity_q     <= ArityReset;
      pend_q      <= 1'b0;
      best_vld_q  <= 1'b0;
      chg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      best_vld_q  <= best_vld_d;
      chg_q       <= chg_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cnt_q == '0) begin
        arity_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    cur_key_q  <= cur_key_d;
    cur_idx_q  <= cur_idx_d;
    prod_q     <= prod_d;
    par_idx_q  <= par_idx_d;
    first_q    <= first_d;
    j_q        <= j_d;
    rd_idx_q   <= rd_idx_d;
    best_key_q <= best_key_d;
    best_idx_q <= best_idx_d;
    scan_q     <= scan_d;
    status_q   <= status_d;
    out_data_q <= out_data_d;
    // cached copy of slot zero
    if (wr_en && wr_addr == '0) begin
      root_q <= wr_data;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/mahq_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mahq_chk: port-level checks for the m-ary min-heap queue
// Watches result items against the count and the channel rules.
// ----------------------------------------------------------------------------
module mahq_chk #(
  parameter int unsigned DEPTH = mahq_pkg::DefDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  mahq_pkg::rsp_t              out_data_o
);
  import mahq_pkg::*;

  // an empty heap reports a zero minimum
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.entry_count == '0 |-> out_data_o.min_key == '0)
    else $error("nonzero min_key on empty heap");

  // a dropped insert means the heap is full
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_FULL |->
      out_data_o.entry_count == CountW'(DEPTH))
    else $error("full status without full count");

  // empty status only when nothing is held
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_EMPTY |-> out_data_o.entry_count == '0)
    else $error("empty status with keys held");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result item changed");

endmodule

bind m_ary_min_heap_queue_unit mahq_chk #(.DEPTH(DEPTH)) u_mahq_chk (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the m-ary min-heap queue unit
// Random and directed requests feed the heap under varying arity settings.
// A local heap predictor computes each expected result, and the monitor
// checks every output item against it.
// ----------------------------------------------------------------------------
module tb_top;
  import mahq_pkg::*;

  localparam int unsigned HeapDepth = 1024;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned HoldCycles = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  rsp_t out_data;
  logic cfg_we = 1'b0;
  logic [ArityW-1:0] cfg_data = '0;

  m_ary_min_heap_queue_unit #(.DEPTH(HeapDepth)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_data_i(cfg_data)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic signed [31:0] heap_keys [HeapDepth];
  int unsigned heap_size = 0;
  logic [3:0] arity_reg = ArityReset;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 79;
  bit hold_req = 1'b0;
  int unsigned hold_cnt = 0;
  bit failed = 1'b0;
  int unsigned cycle_count = 0;

  function automatic int unsigned fanout();
    if (arity_reg < ArityMin) return ArityMin;
    if (arity_reg > ArityMax) return ArityMax;
    return arity_reg;
  endfunction

  function automatic void swap_keys(int unsigned a, int unsigned b);
    logic signed [31:0] t;
    t = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  function automatic void bubble_up(int unsigned i);
    int unsigned p;
    while (i > 0) begin
      p = (i - 1) / fanout();
      if (heap_keys[i] < heap_keys[p]) begin
        swap_keys(i, p);
        i = p;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void bubble_down(int unsigned i);
    int unsigned first;
    int unsigned best;
    forever begin
      first = fanout() * i + 1;
      if (first >= heap_size) break;
      best = first;
      for (int unsigned j = 1; j < fanout() && first + j < heap_size; j++)
        if (heap_keys[first + j] < heap_keys[best]) best = first + j;
      if (heap_keys[best] < heap_keys[i]) begin
        swap_keys(i, best);
        i = best;
      end else begin
        break;
      end
    end
  endfunction

  function automatic rsp_t heap_apply(req_t r);
    rsp_t res;
    int unsigned idx;
    bit hit;
    res.status = ST_OK;
    if (r.kind == KIND_INSERT) begin
      if (heap_size >= HeapDepth) begin
        res.status = ST_FULL;
      end else begin
        heap_keys[heap_size] = r.key;
        heap_size++;
        bubble_up(heap_size - 1);
      end
    end else if (heap_size == 0) begin
      res.status = ST_EMPTY;
    end else if (r.kind == KIND_REMOVE) begin
      heap_size--;
      heap_keys[0] = heap_keys[heap_size];
      bubble_down(0);
    end else if (r.kind == KIND_CHANGE) begin
      hit = 1'b0;
      idx = 0;
      for (int unsigned i = 0; i < heap_size; i++)
        if (!hit && heap_keys[i] == r.key) begin
          hit = 1'b1;
          idx = i;
        end
      if (!hit) begin
        res.status = ST_NOTFOUND;
      end else begin
        heap_keys[idx] = r.new_value;
        if (idx > 0 && heap_keys[idx] < heap_keys[(idx - 1) / fanout()]) bubble_up(idx);
        else bubble_down(idx);
      end
    end
    res.min_key = heap_size != 0 ? heap_keys[0] : '0;
    res.entry_count = heap_size[CountW-1:0];
    return res;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (cycle_count > 0) begin
      if (in_valid && !in_stall) begin
        expected_rsps.push_back(heap_apply(in_data));
        void'(pending_reqs.pop_front());
      end
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= (in_valid && !in_stall) || !in_valid ? pending_reqs[0] : in_data;
      end else if (!(in_valid && in_stall)) begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver hold-off, timed here once the stimulus asks for it
  always @(posedge clk_i) begin
    if (hold_req && hold_cnt < HoldCycles) hold_cnt <= hold_cnt + 1;
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    cycle_count <= cycle_count + 1;
    if (out_valid && !out_stall) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        failed <= 1'b1;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (out_data.min_key !== exp_rsp.min_key)
          $display("%0t: min_key expected %0d actual %0d", $time, exp_rsp.min_key,
                   out_data.min_key);
        if (out_data.entry_count !== exp_rsp.entry_count)
          $display("%0t: entry_count expected %0d actual %0d", $time,
                   exp_rsp.entry_count, out_data.entry_count);
        if (out_data.status !== exp_rsp.status)
          $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status,
                   out_data.status);
        if (out_data !== exp_rsp) failed <= 1'b1;
      end
    end
    out_stall <= (hold_req && hold_cnt < HoldCycles) ||
                 ($urandom_range(99) < recv_idle_pct);
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic req_t make_req(kind_e k, logic [31:0] a, logic [31:0] b);
    req_t r;
    r.kind = k;
    r.key = a;
    r.new_value = b;
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
      @(posedge clk_i);
    // a request whose item is still in flight is not possible, but let sifts settle
    repeat (40) @(posedge clk_i);
  endtask

  // heap is emptied first, arity only takes while empty
  task automatic set_arity(logic [3:0] val);
    wait_drained();
    for (int i = 0; i < heap_size + 4; i++)
      pending_reqs.push_back(make_req(KIND_REMOVE, '0, '0));
    wait_drained();
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_data <= val;
    if (heap_size == 0) arity_reg = val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // mostly insert-heavy so the heap grows deep, with small key range for hits
  task automatic random_phase(int unsigned n, int unsigned ins_pct);
    logic [31:0] k;
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      k = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(60) - 30;
      r = $urandom_range(99);
      if (r < ins_pct) pending_reqs.push_back(make_req(KIND_INSERT, k, $urandom()));
      else if (r < ins_pct + 15)
        pending_reqs.push_back(make_req(KIND_REMOVE, $urandom(), $urandom()));
      else if (r < ins_pct + 22)
        pending_reqs.push_back(make_req(KIND_PEEK, $urandom(), $urandom()));
      else
        pending_reqs.push_back(make_req(KIND_CHANGE, k,
          $urandom_range(1) ? $urandom() : $urandom_range(60) - 30));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: empty cases, extremes, duplicates, change both ways
    pending_reqs.push_back(make_req(KIND_PEEK, '0, '0));
    pending_reqs.push_back(make_req(KIND_REMOVE, '0, '0));
    pending_reqs.push_back(make_req(KIND_CHANGE, 32'd5, 32'd6));
    pending_reqs.push_back(make_req(KIND_INSERT, 32'h7fffffff, '0));
    pending_reqs.push_back(make_req(KIND_INSERT, 32'h80000000, '1));
    pending_reqs.push_back(make_req(KIND_INSERT, 32'd0, '0));
    pending_reqs.push_back(make_req(KIND_INSERT, 32'hffffffff, '0));
    pending_reqs.push_back(make_req(KIND_INSERT, 32'd0, '0));
    pending_reqs.push_back(make_req(KIND_CHANGE, 32'd0, 32'h80000000));
    pending_reqs.push_back(make_req(KIND_CHANGE, 32'h80000000, 32'h7fffffff));
    pending_reqs.push_back(make_req(KIND_CHANGE, 32'd77, 32'd1));
    pending_reqs.push_back(make_req(KIND_PEEK, '1, '1));
    for (int i = 0; i < 6; i++) pending_reqs.push_back(make_req(KIND_REMOVE, '0, '0));
    // out of range values act as the nearest bound
    set_arity(4'd0);
    random_phase(40, 60);
    set_arity(4'd15);
    random_phase(40, 60);
    set_arity(ArityMax);
    random_phase(100, 55);
    // long receiver hold-off so the input backs up
    hold_req = 1'b1;
    random_phase(20, 50);
    wait (hold_cnt >= HoldCycles);
    hold_req = 1'b0;
    wait_drained();
    send_idle_pct = 79;
    recv_idle_pct = 21;
    set_arity(4'd3);
    random_phase(100, 55);
    set_arity(ArityMin);
    // fill to capacity and past it
    for (int i = 0; i < HeapDepth + 3; i++)
      pending_reqs.push_back(make_req(KIND_INSERT, $urandom(), '0));
    random_phase(40, 40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(40, 55);
    wait_drained();
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/mahq_pkg.sv
hw/rtl/m_ary_min_heap_queue_unit.sv
hw/rtl/mahq_chk.sv
tb/tb_top.sv
